### rtl/ewct_pkg.sv
// Package: shared types, constants and codes for the execute-window check table.
`default_nettype none
package ewct_pkg;
	localparam int CONTEXTS = 16;
	localparam int WINDOWS  = 8;
	localparam int CTX_W    = $clog2(CONTEXTS);
	localparam int WIN_W    = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
	localparam int CNT_W    = $clog2(WINDOWS + 1);
	localparam int TAB_W    = $clog2(CONTEXTS * WINDOWS);

	typedef enum logic [1:0] {
		CMD_STAGE  = 2'd0,
		CMD_COMMIT = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_OVERLAP = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  context_req;
		logic [2:0]  slot;
		logic [63:0] first_va;
		logic [63:0] end_va;
		logic [15:0] key_id;
		logic [15:0] win_tag;
		logic [31:0] owner_id;
		logic [7:0]  permissions;
		logic [15:0] policy_id;
		logic [3:0]  window_count;
		logic [63:0] pc;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        allow;
		logic        matched;
		logic [15:0] hit_key_id;
		logic [15:0] hit_win_tag;
		logic [31:0] hit_owner_id;
		logic [7:0]  hit_permissions;
		logic [15:0] hit_policy_id;
	} rsp_t;

	// One window entry: addresses, owner and packed metadata
	typedef struct packed {
		logic [63:0] first_va;
		logic [63:0] end_va;
		logic [31:0] owner;
		logic [55:0] meta;
	} win_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANGE,
		S_PAIR,
		S_COPY,
		S_QUERY,
		S_RESP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic           load_req;
		logic           stage_wr;
		logic           clr_rsp;
		logic           rd_stage;   // read staging slot at idx_i
		logic           chk_range;
		logic           rd_pair;    // read staging slot idx_j
		logic           chk_pair;
		logic           copy_wr;    // write last read slot into table at idx_j
		logic           size_wr;    // write set size (n or zero)
		logic           size_zero;
		logic           rd_tab;     // read table entry idx_i
		logic           chk_hit;
		logic [1:0]     set_status;
		logic           set_status_en;
		logic [WIN_W-1:0] idx_i;
		logic [WIN_W-1:0] idx_j;
	} cmd_bus_t;

	// Datapath to controller
	typedef struct packed {
		req_t           req;
		logic           ctx_ok;
		logic [CNT_W-1:0] n_commit;
		logic [CNT_W-1:0] n_query;
		logic           range_bad;
		logic           pair_bad;
		logic           hit;
	} sts_bus_t;
endpackage
`default_nettype wire

### rtl/ewct_datapath.sv
// Datapath: request register, staging buffer, window table, set sizes and compare units.
`default_nettype none
module ewct_datapath
	import ewct_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire req_t     req_in,
	input  wire cmd_bus_t cmd,
	output sts_bus_t      sts,
	output rsp_t          rsp
);
	req_t req_q;
	win_t stage_mem [WINDOWS];
	win_t tab_mem [CONTEXTS*WINDOWS];
	logic [CNT_W-1:0] size_q [CONTEXTS];
	win_t rd_a_q, rd_b_q, tab_rd_q;
	rsp_t rsp_q;
	logic [CTX_W-1:0] ctx;
	logic [CNT_W-1:0] n_sat;
	logic [TAB_W-1:0] tab_rd_addr, tab_wr_addr;

	assign ctx = req_q.context_req[CTX_W-1:0];
	assign n_sat = (req_q.window_count > 4'(WINDOWS)) ? CNT_W'(WINDOWS)
		: CNT_W'(req_q.window_count);
	assign tab_rd_addr = TAB_W'({ctx, cmd.idx_i});
	assign tab_wr_addr = TAB_W'({ctx, cmd.idx_j});

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req_in;
	end

	// staging buffer
	always_ff @(posedge clk) begin
		if (cmd.stage_wr)
			stage_mem[req_q.slot[WIN_W-1:0]] <= '{req_q.first_va, req_q.end_va,
				req_q.owner_id, {req_q.key_id, req_q.win_tag,
				req_q.permissions, req_q.policy_id}};
		if (cmd.rd_stage) rd_a_q <= stage_mem[cmd.idx_i];
		if (cmd.rd_pair)  rd_b_q <= stage_mem[cmd.idx_j];
	end

	// window table
	always_ff @(posedge clk) begin
		if (cmd.copy_wr) tab_mem[tab_wr_addr] <= rd_a_q;
		if (cmd.rd_tab)  tab_rd_q <= tab_mem[tab_rd_addr];
	end

	// set sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CONTEXTS; k++) size_q[k] <= '0;
		end else if (cmd.size_wr) begin
			size_q[ctx] <= cmd.size_zero ? '0 : n_sat;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.clr_rsp) rsp_q <= '0;
		else begin
			if (cmd.set_status_en) rsp_q.status <= cmd.set_status;
			if (cmd.chk_hit && sts.hit) begin
				rsp_q.allow <= 1'b1;
				rsp_q.matched <= 1'b1;
				rsp_q.hit_key_id <= tab_rd_q.meta[55:40];
				rsp_q.hit_win_tag <= tab_rd_q.meta[39:24];
				rsp_q.hit_permissions <= tab_rd_q.meta[23:16];
				rsp_q.hit_policy_id <= tab_rd_q.meta[15:0];
				rsp_q.hit_owner_id <= tab_rd_q.owner;
			end
		end
	end

	always_comb begin
		sts.req = req_q;
		sts.ctx_ok = ({1'b0, req_q.context_req} < 5'(CONTEXTS));
		sts.n_commit = n_sat;
		sts.n_query = sts.ctx_ok ? size_q[ctx] : '0;
		sts.range_bad = !(rd_a_q.first_va < rd_a_q.end_va);
		sts.pair_bad = (rd_a_q.first_va < rd_b_q.end_va) &&
			(rd_b_q.first_va < rd_a_q.end_va);
		sts.hit = (tab_rd_q.first_va <= req_q.pc) && (req_q.pc < tab_rd_q.end_va);
	end
	assign rsp = rsp_q;
endmodule
`default_nettype wire

### rtl/ewct_ctrl.sv
// Controller: sequences stage, commit checks, table copy, clear and query scan.
`default_nettype none
module ewct_ctrl
	import ewct_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire sts_bus_t sts,
	output cmd_bus_t      cmd
);
	state_t state_q, state_d;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d;
	logic pend_q, pend_d;   // a read issued last cycle awaits its check
	logic [1:0] op;
	logic j_end;

	assign op = sts.req.command;
	assign in_ready = (state_q == S_IDLE) || (state_q == S_RESP && out_ready);
	assign out_valid = (state_q == S_RESP);
	assign j_end = (j_q >= sts.n_commit);

	// next state
	always_comb begin
		state_d = state_q; i_d = i_q; j_d = j_q; pend_d = 1'b0;
		unique case (state_q)
			S_IDLE, S_RESP: begin
				if ((state_q == S_IDLE || out_ready) && in_valid) begin
					state_d = S_RANGE; i_d = '0; j_d = '0;
					pend_d = 1'b0;
				end else if (state_q == S_RESP && out_ready) state_d = S_IDLE;
			end
			S_RANGE: begin
				// decode step, then range scan for commits
				if (op == CMD_STAGE || op == CMD_CLEAR || !sts.ctx_ok) begin
					state_d = S_RESP;
				end else if (op == CMD_QUERY) begin
					state_d = S_QUERY;
				end else if (pend_q && sts.range_bad) begin
					state_d = S_RESP;
				end else if (i_q < sts.n_commit) begin
					i_d = i_q + 1'b1; pend_d = 1'b1;
				end else if (!pend_q) begin
					state_d = S_PAIR; i_d = '0; j_d = CNT_W'(1);
				end
			end
			S_PAIR: begin
				if (pend_q && sts.pair_bad) state_d = S_RESP;
				else if (i_q >= sts.n_commit) begin
					if (!pend_q) begin state_d = S_COPY; i_d = '0; end
				end else if (j_end) begin
					i_d = i_q + 1'b1; j_d = i_q + 2'd2;
				end else begin
					j_d = j_q + 1'b1; pend_d = 1'b1;
				end
			end
			S_COPY: begin
				if (i_q >= sts.n_commit && !pend_q) state_d = S_RESP;
				else if (i_q < sts.n_commit) begin i_d = i_q + 1'b1; pend_d = 1'b1; end
			end
			S_QUERY: begin
				if (pend_q && sts.hit) state_d = S_RESP;
				else if (i_q < sts.n_query) begin i_d = i_q + 1'b1; pend_d = 1'b1; end
				else if (!pend_q) state_d = S_RESP;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.idx_i = i_q[WIN_W-1:0];
		cmd.idx_j = j_q[WIN_W-1:0];
		unique case (state_q)
			S_IDLE, S_RESP: begin
				if ((state_q == S_IDLE || out_ready) && in_valid) begin
					cmd.load_req = 1'b1; cmd.clr_rsp = 1'b1;
				end
			end
			S_RANGE: begin
				if (op == CMD_STAGE) cmd.stage_wr = ({1'b0, sts.req.slot} < 4'(WINDOWS));
				else if (op == CMD_CLEAR) begin
					cmd.size_wr = sts.ctx_ok; cmd.size_zero = 1'b1;
				end else if (op == CMD_COMMIT && sts.ctx_ok) begin
					if (pend_q && sts.range_bad) begin
						cmd.set_status = ST_INVALID; cmd.set_status_en = 1'b1;
					end else if (i_q < sts.n_commit) cmd.rd_stage = 1'b1;
				end
			end
			S_PAIR: begin
				if (pend_q && sts.pair_bad) begin
					cmd.set_status = ST_OVERLAP; cmd.set_status_en = 1'b1;
				end else if (i_q < sts.n_commit && !j_end) begin
					cmd.rd_stage = 1'b1; cmd.rd_pair = 1'b1;
				end
			end
			S_COPY: begin
				// read slot i, write it to the table in the following cycle at i-1
				if (pend_q) begin
					cmd.copy_wr = 1'b1;
					cmd.idx_j = WIN_W'(i_q - 1'b1);
				end
				if (i_q < sts.n_commit) begin
					cmd.rd_stage = 1'b1; cmd.idx_i = i_q[WIN_W-1:0];
				end
				if (i_q >= sts.n_commit && !pend_q) cmd.size_wr = 1'b1;
			end
			S_QUERY: begin
				if (pend_q) cmd.chk_hit = 1'b1;
				if (!(pend_q && sts.hit) && i_q < sts.n_query) cmd.rd_tab = 1'b1;
			end
			default: ;
		endcase
		cmd.chk_range = (state_q == S_RANGE) && pend_q;
		cmd.chk_pair = (state_q == S_PAIR) && pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; i_q <= '0; j_q <= '0; pend_q <= 1'b0;
		end else begin
			state_q <= state_d; i_q <= i_d; j_q <= j_d; pend_q <= pend_d;
		end
	end
endmodule
`default_nettype wire

### rtl/exec_window_check_table.sv
// Top level: execute-window check table, controller plus datapath.
// Usage:
//  - req channel (req_valid/req_ready/req) carries one command per request:
//    stage, commit, clear or query. rsp channel (rsp_valid/rsp_ready/rsp)
//    returns exactly one response per request, in order.
//  - A stage or clear is answered straight after its decode step. A commit
//    of n windows runs a range scan, a pairwise overlap scan over the
//    single staging read port pair and a table copy, and stops early when
//    a check fails. A query scans the context's windows one per cycle
//    through the table read port and stops at the first hit.
//  - One request is processed at a time; a new request is taken in the
//    same cycle the response is taken.
//  - Reset clears every context's window count; tables and staging slots
//    hold no reset value and must be written before being read (the user's
//    duty, unchecked). On a receiver stall the response holds, no request taken.
`default_nettype none
module exec_window_check_table
	import ewct_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);
	cmd_bus_t cmd;
	sts_bus_t sts;

	ewct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req_valid), .in_ready(req_ready),
		.out_valid(rsp_valid), .out_ready(rsp_ready),
		.sts(sts), .cmd(cmd)
	);

	ewct_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.req_in(req), .cmd(cmd), .sts(sts), .rsp(rsp)
	);
endmodule
`default_nettype wire

### rtl/ewct_checker.sv
// Port checker for the execute-window check table, bound to the top level.
`default_nettype none
module ewct_checker
	import ewct_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");
	a_no_req_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while response stalled");
	a_match_allow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.allow == rsp.matched)
		else $error("allow and matched disagree");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != 2'd3)
		else $error("bad status code");
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid)
		else $error("response without processing");
endmodule

bind exec_window_check_table ewct_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
`default_nettype wire

### tb/exec_window_check_table_test.sv
// Testbench for the execute-window check table: directed and random commands checked against a predictor.
`default_nettype none
module exec_window_check_table_test;
	import ewct_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	exec_window_check_table dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Predictor state
	win_t        stg_win [WINDOWS];
	win_t        tab_win [CONTEXTS*WINDOWS];
	int unsigned tab_size [CONTEXTS];

	rsp_t expected_rsp [$];
	int   errors = 0;
	int   send_idle = 0;
	int   recv_idle = 0;
	longint cycles = 0;
	localparam longint CYCLE_LIMIT = 2000000;

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the response to one request and update the predicted table
	function automatic rsp_t predict_window_rsp(req_t r);
		rsp_t o;
		int unsigned n, base;
		logic [1:0] st;
		o = '0;
		base = r.context_req * WINDOWS;
		case (r.command)
			CMD_STAGE: begin
				if (r.slot < WINDOWS) begin
					stg_win[r.slot].first_va = r.first_va;
					stg_win[r.slot].end_va = r.end_va;
					stg_win[r.slot].owner = r.owner_id;
					stg_win[r.slot].meta = {r.key_id, r.win_tag, r.permissions, r.policy_id};
				end
			end
			CMD_COMMIT: begin
				if (r.context_req < CONTEXTS) begin
					n = (r.window_count > WINDOWS) ? WINDOWS : r.window_count;
					st = ST_OK;
					for (int i = 0; i < n; i++)
						if (stg_win[i].first_va >= stg_win[i].end_va) st = ST_INVALID;
					if (st == ST_OK)
						for (int i = 0; i < n; i++)
							for (int j = i + 1; j < n; j++)
								if (stg_win[i].first_va < stg_win[j].end_va &&
								    stg_win[j].first_va < stg_win[i].end_va)
									st = ST_OVERLAP;
					if (st == ST_OK) begin
						for (int i = 0; i < n; i++) tab_win[base+i] = stg_win[i];
						tab_size[r.context_req] = n;
					end
					o.status = st;
				end
			end
			CMD_CLEAR: begin
				if (r.context_req < CONTEXTS) tab_size[r.context_req] = 0;
			end
			default: begin
				if (r.context_req < CONTEXTS)
					for (int i = 0; i < tab_size[r.context_req]; i++) begin
						win_t w;
						w = tab_win[base+i];
						if (w.first_va <= r.pc && r.pc < w.end_va) begin
							o.allow = 1'b1;
							o.matched = 1'b1;
							o.hit_key_id = w.meta[55:40];
							o.hit_win_tag = w.meta[39:24];
							o.hit_permissions = w.meta[23:16];
							o.hit_policy_id = w.meta[15:0];
							o.hit_owner_id = w.owner;
							break;
						end
					end
			end
		endcase
		return o;
	endfunction

	// Send one request, with random idle cycles before it
	task automatic send_request(req_t r);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		expected_rsp.push_back(predict_window_rsp(r));
	endtask

	// Receiver: random stalls, compare each response to the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected response %h", $time, rsp);
					errors++;
				end else begin
					rsp_t e;
					e = expected_rsp.pop_front();
					if (rsp !== e) begin
						$display("%0t: mismatch expected %h actual %h", $time, e, rsp);
						errors++;
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic req_t stage_req(int s, logic [63:0] a, logic [63:0] b);
		req_t r;
		r = '0;
		r.command = CMD_STAGE;
		r.slot = 3'(s);
		r.first_va = a;
		r.end_va = b;
		r.key_id = 16'($urandom);
		r.win_tag = 16'($urandom);
		r.owner_id = $urandom;
		r.permissions = 8'($urandom);
		r.policy_id = 16'($urandom);
		r.context_req = 4'($urandom);
		r.window_count = 4'($urandom);
		r.pc = {$urandom, $urandom};
		return r;
	endfunction

	function automatic req_t cmd_req(cmd_t c, int ctx, int cnt, logic [63:0] pc);
		req_t r;
		r = stage_req($urandom_range(7), {$urandom, $urandom}, {$urandom, $urandom});
		r.command = c;
		r.context_req = 4'(ctx);
		r.window_count = 4'(cnt);
		r.pc = pc;
		return r;
	endfunction

	// Directed: extremes, every command, the error orderings
	task automatic test_directed();
		send_request(stage_req(0, 64'h0, 64'h10));
		send_request(stage_req(1, 64'h10, 64'hFFFF_FFFF_FFFF_FFFF));
		send_request(cmd_req(CMD_COMMIT, 0, 2, 0));
		send_request(cmd_req(CMD_QUERY, 0, 0, 64'h0));
		send_request(cmd_req(CMD_QUERY, 0, 0, 64'hF));
		send_request(cmd_req(CMD_QUERY, 0, 0, 64'h10));
		send_request(cmd_req(CMD_QUERY, 0, 0, 64'hFFFF_FFFF_FFFF_FFFE));
		send_request(cmd_req(CMD_QUERY, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
		send_request(cmd_req(CMD_QUERY, 15, 0, 64'h5));
		// empty range and overlap together: invalid wins
		send_request(stage_req(2, 64'h5, 64'h5));
		send_request(cmd_req(CMD_COMMIT, 15, 3, 0));
		send_request(stage_req(2, 64'h8, 64'h20));
		send_request(cmd_req(CMD_COMMIT, 15, 3, 0));
		send_request(cmd_req(CMD_QUERY, 0, 0, 64'h8));
		send_request(cmd_req(CMD_COMMIT, 15, 0, 0));
		for (int s = 3; s < 8; s++)
			send_request(stage_req(s, 64'h1000 * s, 64'h1000 * s + 64'h100));
		send_request(stage_req(2, 64'h20, 64'h30));
		send_request(cmd_req(CMD_COMMIT, 15, 15, 0));
		send_request(cmd_req(CMD_QUERY, 15, 0, 64'h7050));
		send_request(cmd_req(CMD_CLEAR, 15, 0, 0));
		send_request(cmd_req(CMD_QUERY, 15, 0, 64'h7050));
	endtask

	// Random: mostly well formed windows sets with random content
	task automatic test_random(int items);
		int k;
		k = 0;
		while (k < items) begin
			int n, kind, ctx;
			logic [63:0] base, pc;
			kind = $urandom_range(99);
			ctx = $urandom_range(15);
			if (kind < 45) begin
				n = $urandom_range(8);
				base = (kind < 10) ? {$urandom, $urandom} : 64'($urandom_range(4096));
				for (int s = 0; s < 8; s++) begin
					logic [63:0] a, len;
					len = 64'($urandom_range(64));
					a = base + 64'(s * 128) + 64'($urandom_range(32));
					if ($urandom_range(19) == 0) len = 0;
					if ($urandom_range(19) == 0) a = base + 64'(s > 0 ? (s - 1) * 128 : 0);
					send_request(stage_req(s, a, a + len));
				end
				send_request(cmd_req(CMD_COMMIT, ctx, ($urandom_range(9) == 0) ?
					$urandom_range(15) : n, 0));
				k += 9;
			end else if (kind < 50) begin
				send_request(cmd_req(CMD_CLEAR, ctx, 0, 0));
				k++;
			end else if (kind < 55) begin
				send_request(stage_req($urandom_range(7), {$urandom, $urandom},
					{$urandom, $urandom}));
				k++;
			end else begin
				pc = ($urandom_range(9) == 0) ? {$urandom, $urandom} :
					64'($urandom_range(6000));
				if ($urandom_range(9) == 0)
					pc = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
				send_request(cmd_req(CMD_QUERY, ctx, $urandom, pc));
				k++;
			end
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < CONTEXTS; i++) tab_size[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 8; recv_idle = 53;
		test_directed();
		test_random(270);
		send_idle = 53; recv_idle = 8;
		test_random(270);
		send_idle = 0; recv_idle = 0;
		test_random(270);
		drain();
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
rtl/ewct_pkg.sv
rtl/ewct_datapath.sv
rtl/ewct_ctrl.sv
rtl/exec_window_check_table.sv
rtl/ewct_checker.sv
tb/exec_window_check_table_test.sv
